// File: rtl/ivma_pkg.sv
// shared types and constants for the int8 vector metric accumulator
package ivma_pkg;

   typedef enum logic [1:0] {
      MODE_DOT      = 2'd0,
      MODE_SQDIST   = 2'd1,
      MODE_HAMMING  = 2'd2,
      MODE_POPCOUNT = 2'd3
   } metric_mode_type;

   localparam int MAX_LANES = 8;
   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 64;
   localparam int COUNT_W   = 4;
   localparam int TERM_W    = 17;
   localparam int SUM_W     = 21;
   localparam int ACC_W     = 64;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0] REG_METRIC_MODE = 1'b0;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic                    last;
      logic signed [SUM_W-1:0] contrib;
   } sum_item_type;

endpackage

// File: rtl/ivma_lane.sv
// one byte lane: product, squared difference or bit count for a byte pair
module ivma_lane (
   input  logic [ivma_pkg::BYTE_W-1:0]         left_byte,
   input  logic [ivma_pkg::BYTE_W-1:0]         right_byte,
   input  ivma_pkg::metric_mode_type           mode,
   input  logic                                lane_on,
   output logic signed [ivma_pkg::TERM_W-1:0]  term
);

   logic signed [7:0]  a;
   logic signed [7:0]  b;
   logic signed [8:0]  diff;
   logic signed [15:0] prod;
   logic signed [17:0] square;
   logic [7:0]         bits;
   logic [3:0]         ones;

   assign a      = $signed(left_byte);
   assign b      = $signed(right_byte);
   assign diff   = $signed({a[7], a}) - $signed({b[7], b});
   assign prod   = a * b;
   assign square = diff * diff;
   assign bits   = (mode == ivma_pkg::MODE_POPCOUNT) ? left_byte : (left_byte ^ right_byte);

   always_comb begin
      ones = 4'd0;
      for (int i = 0; i < 8; i++) begin
         ones = ones + {3'd0, bits[i]};
      end
   end

   always_comb begin
      term = '0;
      if (lane_on) begin
         case (mode)
            ivma_pkg::MODE_DOT:      term = {prod[15], prod};
            ivma_pkg::MODE_SQDIST:   term = $signed(square[16:0]);
            ivma_pkg::MODE_HAMMING:  term = $signed({13'd0, ones});
            ivma_pkg::MODE_POPCOUNT: term = $signed({13'd0, ones});
            default:                 term = '0;
         endcase
      end
   end

endmodule

// File: rtl/ivma_accum.sv
// saturating 64-bit running sum and result register
module ivma_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  ivma_pkg::sum_item_type              item,
   output logic                                item_take,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ivma_pkg::ACC_W-1:0]   rsp_metric_value
);

   logic signed [ivma_pkg::ACC_W-1:0] run_ff, run_in;
   logic signed [ivma_pkg::ACC_W-1:0] value_ff, value_in;
   logic                              valid_ff, valid_in;
   logic signed [ivma_pkg::ACC_W-1:0] addend;
   logic signed [ivma_pkg::ACC_W:0]   wide;
   logic signed [ivma_pkg::ACC_W-1:0] sat_sum;
   logic                              emit;

   assign addend = {{(ivma_pkg::ACC_W-ivma_pkg::SUM_W){item.contrib[ivma_pkg::SUM_W-1]}},
                    item.contrib};
   assign wide   = $signed({run_ff[ivma_pkg::ACC_W-1], run_ff})
                 + $signed({addend[ivma_pkg::ACC_W-1], addend});

   always_comb begin
      if (wide[ivma_pkg::ACC_W] != wide[ivma_pkg::ACC_W-1]) begin
         sat_sum = wide[ivma_pkg::ACC_W] ? ivma_pkg::ACC_MIN : ivma_pkg::ACC_MAX;
      end else begin
         sat_sum = wide[ivma_pkg::ACC_W-1:0];
      end
   end

   // a last item needs the result register free or leaving
   assign item_take = item_valid && (!item.last || !valid_ff || !rsp_stall);
   assign emit      = item_take && item.last;

   always_comb begin
      run_in   = run_ff;
      value_in = value_ff;
      valid_in = valid_ff && rsp_stall;
      if (item_take) begin
         run_in = item.last ? '0 : sat_sum;
      end
      if (emit) begin
         value_in = sat_sum;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_metric_value = value_ff;

endmodule

// File: rtl/int8_vector_metric_accumulator.sv
// top level: csr, input register, lane terms, lane sum and accumulator
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| left_word, right_word, valid_bytes, last_item
//  rsp     | out       | rsp_valid/rsp_stall| metric_value
//  csr     | in/out    | apb psel/penable   | metric_mode at byte address 0
//
// one item per cycle while req_stall is low; rsp shows the accumulator's result register
// the stages are input register, lane terms, lane sum, then the saturating accumulator
// empty stages close up, and only a last item waits on a stalled result
// synchronous reset clears valids, the running sum and metric_mode
module int8_vector_metric_accumulator #(
   parameter int LANES = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ivma_pkg::WORD_W-1:0]            req_left_word,
   input  logic [ivma_pkg::WORD_W-1:0]            req_right_word,
   input  logic [ivma_pkg::COUNT_W-1:0]           req_valid_bytes,
   input  logic                                   req_last_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ivma_pkg::ACC_W-1:0]      rsp_metric_value,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ivma_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [ivma_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [ivma_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int ACTIVE_LANES = (LANES < ivma_pkg::MAX_LANES) ? LANES : ivma_pkg::MAX_LANES;
   localparam logic [ivma_pkg::COUNT_W-1:0] CNT_LIMIT = ivma_pkg::COUNT_W'(ACTIVE_LANES);

   // csr
   ivma_pkg::metric_mode_type mode_ff, mode_in;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                     && (csr_paddr[2:2] == ivma_pkg::REG_METRIC_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (csr_write) begin
         mode_in = ivma_pkg::metric_mode_type'(csr_pwdata[1:0]);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2:2] == ivma_pkg::REG_METRIC_MODE) begin
         csr_prdata = {{(ivma_pkg::CSR_DATA_W-2){1'b0}}, mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ivma_pkg::MODE_DOT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // pipeline control
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic take3, move2, move1, free3, free2, free1, accept;

   assign free3  = !v3_ff || take3;
   assign move2  = v2_ff && free3;
   assign free2  = !v2_ff || move2;
   assign move1  = v1_ff && free2;
   assign free1  = !v1_ff || move1;
   assign accept = req_valid && free1;

   assign req_stall = !free1;

   assign v1_in = accept || (v1_ff && !move1);
   assign v2_in = move1  || (v2_ff && !move2);
   assign v3_in = move2  || (v3_ff && !take3);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // input register
   logic [ivma_pkg::WORD_W-1:0]  s1_left_ff, s1_left_in;
   logic [ivma_pkg::WORD_W-1:0]  s1_right_ff, s1_right_in;
   logic [ivma_pkg::COUNT_W-1:0] s1_cnt_ff, s1_cnt_in;
   logic                         s1_last_ff, s1_last_in;
   ivma_pkg::metric_mode_type    s1_mode_ff, s1_mode_in;

   always_comb begin
      s1_left_in  = s1_left_ff;
      s1_right_in = s1_right_ff;
      s1_cnt_in   = s1_cnt_ff;
      s1_last_in  = s1_last_ff;
      s1_mode_in  = s1_mode_ff;
      if (accept) begin
         s1_left_in  = req_left_word;
         s1_right_in = req_right_word;
         s1_cnt_in   = (req_valid_bytes > CNT_LIMIT) ? CNT_LIMIT : req_valid_bytes;
         s1_last_in  = req_last_item;
         s1_mode_in  = mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_left_ff  <= s1_left_in;
      s1_right_ff <= s1_right_in;
      s1_cnt_ff   <= s1_cnt_in;
      s1_last_ff  <= s1_last_in;
      s1_mode_ff  <= s1_mode_in;
   end

   // lane terms
   logic signed [ivma_pkg::TERM_W-1:0] lane_term [ACTIVE_LANES];
   logic signed [ivma_pkg::TERM_W-1:0] s2_term_ff [ACTIVE_LANES];
   logic signed [ivma_pkg::TERM_W-1:0] s2_term_in [ACTIVE_LANES];
   logic                               s2_last_ff, s2_last_in;

   for (genvar i = 0; i < ACTIVE_LANES; i++) begin : g_lane
      ivma_lane u_lane (
         .left_byte  (s1_left_ff[ivma_pkg::BYTE_W*i +: ivma_pkg::BYTE_W]),
         .right_byte (s1_right_ff[ivma_pkg::BYTE_W*i +: ivma_pkg::BYTE_W]),
         .mode       (s1_mode_ff),
         .lane_on    (s1_cnt_ff > ivma_pkg::COUNT_W'(i)),
         .term       (lane_term[i])
      );
   end

   always_comb begin
      for (int i = 0; i < ACTIVE_LANES; i++) begin
         s2_term_in[i] = move1 ? lane_term[i] : s2_term_ff[i];
      end
      s2_last_in = move1 ? s1_last_ff : s2_last_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ACTIVE_LANES; i++) begin
         s2_term_ff[i] <= s2_term_in[i];
      end
      s2_last_ff <= s2_last_in;
   end

   // lane sum
   logic signed [ivma_pkg::SUM_W-1:0] lane_sum;
   ivma_pkg::sum_item_type            s3_ff, s3_in;

   always_comb begin
      lane_sum = '0;
      for (int i = 0; i < ACTIVE_LANES; i++) begin
         lane_sum = lane_sum
                  + $signed({{(ivma_pkg::SUM_W-ivma_pkg::TERM_W){s2_term_ff[i][ivma_pkg::TERM_W-1]}},
                             s2_term_ff[i]});
      end
   end

   always_comb begin
      s3_in = s3_ff;
      if (move2) begin
         s3_in.last    = s2_last_ff;
         s3_in.contrib = lane_sum;
      end
   end

   always_ff @(posedge clock) begin
      s3_ff <= s3_in;
   end

   ivma_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (v3_ff),
      .item             (s3_ff),
      .item_take        (take3),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_metric_value (rsp_metric_value)
   );

endmodule

// File: bench/int8_vector_metric_accumulator_tb.sv
// testbench for int8_vector_metric_accumulator: csr access, four metric modes, idling and stall
`timescale 1ns / 1ps

module int8_vector_metric_accumulator_tb;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 500;
   localparam logic [ivma_pkg::CSR_ADDR_W-1:0] MODE_ADDR =
      ivma_pkg::CSR_ADDR_W'({ivma_pkg::REG_METRIC_MODE, 2'b00});
   localparam logic [ivma_pkg::CSR_ADDR_W-1:0] UNUSED_ADDR = ivma_pkg::CSR_ADDR_W'(4);
   localparam logic [ivma_pkg::WORD_W-1:0] BYTES_MIN = {8{8'h80}};
   localparam logic [ivma_pkg::WORD_W-1:0] BYTES_MAX = {8{8'h7F}};
   localparam logic [ivma_pkg::WORD_W-1:0] BYTES_ONES = {8{8'hFF}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ivma_pkg::WORD_W-1:0] req_left_word = '0;
   logic [ivma_pkg::WORD_W-1:0] req_right_word = '0;
   logic [ivma_pkg::COUNT_W-1:0] req_valid_bytes = '0;
   logic req_last_item = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ivma_pkg::ACC_W-1:0] rsp_metric_value;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ivma_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ivma_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [ivma_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   ivma_pkg::metric_mode_type model_mode = ivma_pkg::MODE_DOT;
   longint model_running_sum = 0;
   longint expected_metrics[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int vectors_per_mode[4] = '{0, 0, 0, 0};
   int cycle_count = 0;

   int8_vector_metric_accumulator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_left_word(req_left_word),
      .req_right_word(req_right_word),
      .req_valid_bytes(req_valid_bytes),
      .req_last_item(req_last_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_metric_value(rsp_metric_value),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("int8_vector_metric_accumulator_tb NOT OK");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_metrics.size() == 0) begin
            error_count++;
            $error("unexpected result metric_value=%0d", rsp_metric_value);
         end else begin
            if (rsp_metric_value !== expected_metrics[0]) begin
               error_count++;
               $error("metric_value expected %0d actual %0d", expected_metrics[0],
                      rsp_metric_value);
            end
            void'(expected_metrics.pop_front());
            results_checked++;
         end
      end
   end

   function automatic longint metric_contribution(ivma_pkg::metric_mode_type mode,
                                                  logic [ivma_pkg::WORD_W-1:0] lw,
                                                  logic [ivma_pkg::WORD_W-1:0] rw,
                                                  logic [ivma_pkg::COUNT_W-1:0] count);
      int lanes;
      logic [ivma_pkg::WORD_W-1:0] byte_mask;
      logic signed [ivma_pkg::BYTE_W-1:0] a;
      logic signed [ivma_pkg::BYTE_W-1:0] b;
      longint diff;
      longint total;
      lanes = (count > ivma_pkg::MAX_LANES) ? ivma_pkg::MAX_LANES : int'(count);
      byte_mask = '0;
      total = 0;
      for (int i = 0; i < ivma_pkg::MAX_LANES; i++) begin
         if (i < lanes) byte_mask[8*i +: 8] = 8'hFF;
      end
      case (mode)
         ivma_pkg::MODE_DOT: begin
            for (int i = 0; i < lanes; i++) begin
               a = lw[8*i +: 8];
               b = rw[8*i +: 8];
               total += longint'(a) * longint'(b);
            end
         end
         ivma_pkg::MODE_SQDIST: begin
            for (int i = 0; i < lanes; i++) begin
               a = lw[8*i +: 8];
               b = rw[8*i +: 8];
               diff = longint'(a) - longint'(b);
               total += diff * diff;
            end
         end
         ivma_pkg::MODE_HAMMING: total = longint'($countones((lw ^ rw) & byte_mask));
         default: total = longint'($countones(lw & byte_mask));
      endcase
      return total;
   endfunction

   function automatic longint add_saturating(longint acc, longint term);
      logic [ivma_pkg::ACC_W:0] wide;
      wide = {acc[ivma_pkg::ACC_W-1], acc} + {term[ivma_pkg::ACC_W-1], term};
      if (wide[ivma_pkg::ACC_W] != wide[ivma_pkg::ACC_W-1]) begin
         return wide[ivma_pkg::ACC_W] ? ivma_pkg::ACC_MIN : ivma_pkg::ACC_MAX;
      end
      return wide[ivma_pkg::ACC_W-1:0];
   endfunction

   function automatic logic [ivma_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(7))
         0: return BYTES_MIN;
         1: return BYTES_MAX;
         2: return BYTES_ONES;
         3: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one input transfer, with random sender idling ahead of it
   task automatic send_item(input logic [ivma_pkg::WORD_W-1:0] lw,
                            input logic [ivma_pkg::WORD_W-1:0] rw,
                            input logic [ivma_pkg::COUNT_W-1:0] count, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_left_word = lw;
      req_right_word = rw;
      req_valid_bytes = count;
      req_last_item = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_running_sum = add_saturating(model_running_sum,
                                         metric_contribution(model_mode, lw, rw, count));
      if (last) begin
         expected_metrics.push_back(model_running_sum);
         model_running_sum = 0;
         vectors_per_mode[model_mode]++;
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_metrics.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // apb write followed by a read back of metric_mode
   task automatic csr_write(input logic [ivma_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [ivma_pkg::CSR_DATA_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == MODE_ADDR) model_mode = ivma_pkg::metric_mode_type'(value[1:0]);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = MODE_ADDR;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== ivma_pkg::CSR_DATA_W'(model_mode)) begin
         error_count++;
         $error("metric_mode expected %0d actual %0d", model_mode, csr_prdata);
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic send_random_vector();
      int len;
      logic [ivma_pkg::COUNT_W-1:0] count;
      len = ($urandom_range(15) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) count = ivma_pkg::COUNT_W'($urandom_range(15));
         else if (i == len - 1) count = ivma_pkg::COUNT_W'($urandom_range(ivma_pkg::MAX_LANES));
         else count = ivma_pkg::COUNT_W'(ivma_pkg::MAX_LANES);
         send_item(random_word(), random_word(), count, i == len - 1);
      end
   endtask

   task automatic test_csr();
      csr_write(MODE_ADDR, ivma_pkg::CSR_DATA_W'(ivma_pkg::MODE_HAMMING));
      csr_write(MODE_ADDR, '1);
      csr_write(UNUSED_ADDR, ivma_pkg::CSR_DATA_W'(ivma_pkg::MODE_SQDIST));
      csr_write(MODE_ADDR, 32'hFFFF_FFFC | ivma_pkg::CSR_DATA_W'(ivma_pkg::MODE_SQDIST));
      csr_write(MODE_ADDR, ivma_pkg::CSR_DATA_W'(ivma_pkg::MODE_DOT));
   endtask

   task automatic test_extremes();
      idle_pct = 25;
      stall_pct = 25;
      for (int m = 0; m < 4; m++) begin
         drain();
         csr_write(MODE_ADDR, ivma_pkg::CSR_DATA_W'(m));
         send_item(BYTES_MIN, BYTES_MIN, ivma_pkg::COUNT_W'(ivma_pkg::MAX_LANES), 1'b1);
         send_item(BYTES_MIN, BYTES_MAX, ivma_pkg::COUNT_W'(ivma_pkg::MAX_LANES), 1'b1);
         send_item(BYTES_ONES, '0, '1, 1'b1);
         send_item({32{2'b01}}, {32{2'b10}}, ivma_pkg::COUNT_W'(3), 1'b0);
         send_item(BYTES_ONES, BYTES_MIN, '0, 1'b1);
      end
   endtask

   task automatic test_mode_change_mid_vector();
      drain();
      csr_write(MODE_ADDR, ivma_pkg::CSR_DATA_W'(ivma_pkg::MODE_DOT));
      send_item(BYTES_MIN, BYTES_MIN, ivma_pkg::COUNT_W'(ivma_pkg::MAX_LANES), 1'b0);
      drain();
      csr_write(MODE_ADDR, ivma_pkg::CSR_DATA_W'(ivma_pkg::MODE_SQDIST));
      send_item({$urandom, $urandom}, {$urandom, $urandom},
                ivma_pkg::COUNT_W'(ivma_pkg::MAX_LANES), 1'b0);
      drain();
      csr_write(MODE_ADDR, ivma_pkg::CSR_DATA_W'(ivma_pkg::MODE_POPCOUNT));
      send_item(BYTES_ONES, '0, ivma_pkg::COUNT_W'(9), 1'b1);
   endtask

   task automatic test_random_phase(input int sender_idle, input int receiver_stall);
      int phase_start;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      for (int m = 0; m < 4; m++) begin
         drain();
         csr_write(MODE_ADDR, ($urandom & 32'hFFFF_FFFC) | ivma_pkg::CSR_DATA_W'(m));
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS / 4) send_random_vector();
      end
   endtask

   task automatic test_backpressure();
      drain();
      csr_write(MODE_ADDR, ivma_pkg::CSR_DATA_W'($urandom_range(3)));
      idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 300;
      for (int i = 0; i < 40; i++) send_random_vector();
   endtask

   task automatic test_pause_until_drained();
      idle_pct = 10;
      stall_pct = 30;
      for (int i = 0; i < 10; i++) send_random_vector();
      drain();
      for (int i = 0; i < 10; i++) send_random_vector();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_csr();
      test_extremes();
      test_mode_change_mid_vector();
      test_random_phase(0, 0);
      test_random_phase(78, 0);
      test_random_phase(0, 78);
      test_random_phase(25, 25);
      test_backpressure();
      test_pause_until_drained();
      drain();
      $display("%0d input transfers and %0d results checked", items_sent, results_checked);
      $display("vectors per mode: dot %0d, sqdist %0d, hamming %0d, popcount %0d",
               vectors_per_mode[ivma_pkg::MODE_DOT], vectors_per_mode[ivma_pkg::MODE_SQDIST],
               vectors_per_mode[ivma_pkg::MODE_HAMMING],
               vectors_per_mode[ivma_pkg::MODE_POPCOUNT]);
      if (error_count == 0 && expected_metrics.size() == 0) begin
         $display("int8_vector_metric_accumulator_tb OK");
      end else begin
         $display("int8_vector_metric_accumulator_tb NOT OK");
      end
      $finish;
   end

endmodule
